// File: rtl/mspr_pkg.sv
`timescale 1ns / 1ps

package mspr_pkg;

    localparam int NODES_DEFAULT        = 4;
    localparam int BUFFER_WORDS_DEFAULT = 1024;
    localparam int PACKET_WORDS_DEFAULT = 256;

    localparam int DATA_W         = 32;
    localparam int NODE_W         = 4;
    localparam int POS_W          = 8;
    localparam int BYTES_W        = 11;
    localparam int READ_INDEX_W   = 10;
    localparam int MSG_WORDS_W    = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 1;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 2;

    localparam int LOCAL_NODE_RESET = 0;
    localparam int MSG_WORDS_RESET  = 338;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_NODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MESSAGE_WORDS = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_STORE   = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_LOCAL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RELOAD
    } state_t;

    // offset of remote slot after reset, saturated to the buffer size
    function automatic int reset_offset(input int node, input int buf_words);
        int m;
        int v;
        m = MSG_WORDS_RESET;
        if (m > buf_words)
        begin
            m = buf_words;
        end
        v = node * m;
        if (v > buf_words)
        begin
            v = buf_words;
        end
        return v;
    endfunction

endpackage

// File: rtl/mspr_ram.sv
`timescale 1ns / 1ps

module mspr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/multi_source_packet_reassembly_unit.sv
`timescale 1ns / 1ps
// Reassembly buffer for payload words from NODES-1 remote nodes.
// Input channel (in_valid/in_ready) carries one request: kind selects store,
// read or restart. Output channel (out_valid/out_ready) returns exactly one
// result per request, in request order, from an output register.
// Store: payload word written at the source's offset plus word_position;
//   result in the cycle after the request; one store per cycle unless out_ready stalls.
// Read: the buffer RAM is read while the owning node is found by repeated
//   subtraction of message_words, one per whole message below read_index
//   (at most NODES-1); the registered result follows the last subtraction.
// Restart: result in the cycle after the request; the offset table is then
//   rebuilt one entry per cycle, all NODES-1 entries, with in_ready low.
// Config writes (cfg_write) take effect at once; write only while idle.
// Reset: local_node 0, message_words 338, offsets slot*338 saturated at
//   BUFFER_WORDS; buffer contents undefined until written.
// Receiver stall: the result waits in the output register, and a new
// request is taken only in the cycle the output register is free or freed.
module multi_source_packet_reassembly_unit
    import mspr_pkg::*;
#(
    parameter int NODES        = NODES_DEFAULT,
    parameter int BUFFER_WORDS = BUFFER_WORDS_DEFAULT,
    parameter int PACKET_WORDS = PACKET_WORDS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [KIND_W-1:0]              kind,
    input  logic [NODE_W-1:0]              source_node,
    input  logic signed [DATA_W-1:0]       payload_word,
    input  logic [POS_W-1:0]               word_position,
    input  logic [BYTES_W-1:0]             byte_count,
    input  logic                           end_of_packet,
    input  logic [READ_INDEX_W-1:0]        read_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [DATA_W-1:0]       read_word,
    output logic [NODE_W-1:0]              from_node,
    output logic                           last_word,
    output logic [STATUS_W-1:0]            status
);

    localparam int REMOTES = NODES - 1;
    localparam int CW      = $clog2(BUFFER_WORDS + 1);
    localparam int AW      = $clog2(BUFFER_WORDS);
    localparam int OW      = (REMOTES > 1) ? $clog2(REMOTES) : 1;
    localparam int QW      = $clog2(REMOTES + 1);
    localparam int WW      = ((CW > MSG_WORDS_W) ? CW : MSG_WORDS_W) + 1;

    state_t                  state_reg, state_next;
    logic [NODE_W-1:0]       local_node_reg;
    logic [MSG_WORDS_W-1:0]  msg_words_reg;
    logic [CW-1:0]           offset_reg [REMOTES];
    logic [READ_INDEX_W-1:0] rem_reg;
    logic [QW-1:0]           q_reg;
    logic                    rd_ok_reg;
    logic [CW-1:0]           acc_reg;
    logic [OW-1:0]           rl_idx_reg;

    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_word_reg;
    logic [NODE_W-1:0]       out_node_reg;
    logic                    out_last_reg;
    status_t                 out_status_reg;

    logic                    accept;
    logic [WW-1:0]           m_eff;
    logic [WW-1:0]           msg_ext;

    logic                    is_local;
    logic [NODE_W-1:0]       renum;
    logic                    remote_ok;
    logic [OW-1:0]           slot;
    logic [CW-1:0]           off_cur;
    logic [WW-1:0]           vw_raw;
    logic [WW-1:0]           vw;
    logic                    pos_in;
    logic [WW-1:0]           addr_sum;
    logic                    addr_ok;
    logic [WW-1:0]           adv_sum;
    logic [CW-1:0]           adv_sat;
    logic                    store_go;
    logic                    off_upd;

    logic [WW-1:0]           rd_ext;
    logic                    rd_in_buf;
    logic                    ram_re;
    logic [DATA_W-1:0]       ram_rdata;

    logic                    div_cont;
    logic                    div_done;
    logic                    in_range;
    logic [NODE_W-1:0]       q_node;
    logic [WW-1:0]           acc_sum;
    logic [CW-1:0]           acc_sat;
    logic                    reload_done;

    logic                    res_load;
    logic [DATA_W-1:0]       res_word;
    logic [NODE_W-1:0]       res_node;
    logic                    res_last;
    status_t                 res_status;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // message_words clamped to 1..BUFFER_WORDS
    always_comb
    begin
        msg_ext = WW'(msg_words_reg);
        if (msg_ext == '0)
        begin
            m_eff = WW'(1);
        end
        else if (msg_ext > WW'(BUFFER_WORDS))
        begin
            m_eff = WW'(BUFFER_WORDS);
        end
        else
        begin
            m_eff = msg_ext;
        end
    end

    // store path
    always_comb
    begin
        is_local  = (source_node == local_node_reg);
        renum     = (source_node > local_node_reg) ? source_node - NODE_W'(1) : source_node;
        remote_ok = (WW'(renum) < WW'(REMOTES));
        slot      = renum[OW-1:0];
        off_cur   = offset_reg[slot];
        vw_raw    = WW'(byte_count >> 2);
        vw        = (vw_raw > WW'(PACKET_WORDS)) ? WW'(PACKET_WORDS) : vw_raw;
        pos_in    = (WW'(word_position) < vw);
        addr_sum  = WW'(off_cur) + WW'(word_position);
        addr_ok   = (addr_sum < WW'(BUFFER_WORDS));
        adv_sum   = WW'(off_cur) + vw;
        adv_sat   = (adv_sum > WW'(BUFFER_WORDS)) ? CW'(BUFFER_WORDS) : adv_sum[CW-1:0];
        store_go  = accept && (kind == KIND_STORE) && !is_local && remote_ok;
        off_upd   = store_go && end_of_packet;
    end

    // read path
    assign rd_ext    = WW'(read_index);
    assign rd_in_buf = (rd_ext < WW'(BUFFER_WORDS));
    assign ram_re    = accept && (kind == KIND_READ) && rd_in_buf;

    mspr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (BUFFER_WORDS)
    ) u_buffer (
        .clk   (clk),
        .we    (store_go && pos_in && addr_ok),
        .waddr (addr_sum[AW-1:0]),
        .wdata (payload_word),
        .re    (ram_re),
        .raddr (rd_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        div_cont = (WW'(rem_reg) >= m_eff) && (q_reg != QW'(REMOTES));
        div_done = (state_reg == ST_DIV) && !div_cont;
        in_range = (q_reg != QW'(REMOTES)) && rd_ok_reg;
        q_node   = NODE_W'(q_reg);
        acc_sum  = WW'(acc_reg) + m_eff;
        acc_sat  = (acc_sum > WW'(BUFFER_WORDS)) ? CW'(BUFFER_WORDS) : acc_sum[CW-1:0];
        reload_done = (rl_idx_reg == OW'(REMOTES - 1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_READ))
                begin
                    state_next = ST_DIV;
                end
                else if (accept && (kind == KIND_RESTART))
                begin
                    state_next = ST_RELOAD;
                end
            end
            ST_DIV:
            begin
                if (!div_cont)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RELOAD:
            begin
                if (reload_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result
    always_comb
    begin
        res_load   = 1'b0;
        res_word   = '0;
        res_node   = '0;
        res_last   = 1'b0;
        res_status = STATUS_OK;
        if (div_done)
        begin
            res_load = 1'b1;
            if (in_range)
            begin
                res_word = ram_rdata;
                res_node = (q_node >= local_node_reg) ? q_node + NODE_W'(1) : q_node;
                res_last = (q_reg == QW'(REMOTES - 1)) && (WW'(rem_reg) == m_eff - WW'(1));
            end
            else
            begin
                res_status = STATUS_RANGE;
            end
        end
        else if (accept && (kind != KIND_READ))
        begin
            res_load = 1'b1;
            if (kind == KIND_STORE)
            begin
                if (is_local)
                begin
                    res_status = STATUS_LOCAL;
                end
                else if (!remote_ok || (pos_in && !addr_ok))
                begin
                    res_status = STATUS_RANGE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            local_node_reg <= NODE_W'(LOCAL_NODE_RESET);
            msg_words_reg  <= MSG_WORDS_W'(MSG_WORDS_RESET);
            for (int i = 0; i < REMOTES; i++)
            begin
                offset_reg[i] <= CW'(reset_offset(i, BUFFER_WORDS));
            end
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_LOCAL_NODE:    local_node_reg <= cfg_data[NODE_W-1:0];
                    CFG_MESSAGE_WORDS: msg_words_reg  <= cfg_data[MSG_WORDS_W-1:0];
                    default:           local_node_reg <= local_node_reg;
                endcase
            end
            if (off_upd)
            begin
                offset_reg[slot] <= adv_sat;
            end
            if (state_reg == ST_RELOAD)
            begin
                offset_reg[rl_idx_reg] <= acc_reg;
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_reg    <= read_index;
            q_reg      <= '0;
            rd_ok_reg  <= rd_in_buf;
            acc_reg    <= '0;
            rl_idx_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_cont)
        begin
            rem_reg <= rem_reg - READ_INDEX_W'(m_eff);
            q_reg   <= q_reg + QW'(1);
        end
        else if (state_reg == ST_RELOAD)
        begin
            acc_reg    <= acc_sat;
            rl_idx_reg <= rl_idx_reg + OW'(1);
        end
        if (res_load)
        begin
            out_word_reg   <= res_word;
            out_node_reg   <= res_node;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_word = out_word_reg;
    assign from_node = out_node_reg;
    assign last_word = out_last_reg;
    assign status    = out_status_reg;

    a_restart_reloads: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == KIND_RESTART)) |=> (state_reg == ST_RELOAD))
        else $error("restart did not start the offset reload");

    a_busy_no_request: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("request taken while busy");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (!out_valid_reg || out_ready))
        else $error("read result would overwrite a pending result");

    a_last_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_status_reg == STATUS_OK))
        else $error("last flag on a failed request");

    a_local_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STATUS_LOCAL))
            |-> ((out_word_reg == '0) && (out_node_reg == '0)))
        else $error("local-node result carries data");

endmodule
